FILE: design/bxds_pkg.sv
// Package for the 4x4 box-average downscaler.
// Holds shared constants, the register index codes and the stage-one request type.
// No dependencies.
package bxds_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned RUN_W = 10;
  localparam int unsigned COLSUM_W = 12;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned ROW_W = 13;
  localparam logic [ROW_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [CFG_W-1:0] BLOCK_SIZE = 13'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_IN_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IN_HEIGHT = 8'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef logic [CHANNELS-1:0][PIXEL_W-1:0] pixel_t;
  typedef logic [CHANNELS-1:0][RUN_W-1:0] run_sum_t;
  typedef logic [CHANNELS-1:0][COLSUM_W-1:0] col_sum_t;

  typedef struct packed {
    run_sum_t run;
    logic     first_row;
    logic     emit;
    logic     frame_last;
  } acc_req_t;

endpackage

FILE: design/bxds_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read data holds while no read is enabled. No dependencies.
module bxds_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/bxds_front.sv
// Input stage: column and row counters, the running sum of four pixels in a row,
// and the column-sum read request. Depends on bxds_pkg.
module bxds_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  bxds_pkg::pixel_t                      pixel,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        width_use,
  input  logic [bxds_pkg::ROW_W-1:0]            height_use,
  output logic                                  req_load,
  output bxds_pkg::acc_req_t                    req,
  output logic [$clog2(MAX_WIDTH/4)-1:0]        req_addr
);
  import bxds_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned GW = $clog2(MAX_WIDTH / 4);

  logic [CW-1:0]    col;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;
  run_sum_t         row_run_sum;
  run_sum_t         row_run_sum_next;

  logic [CW-1:0]    used_w;
  logic [ROW_W-1:0] used_h;
  logic [CW-1:0]    col_inc;
  logic [ROW_W-1:0] row_inc;
  logic             in_region;
  logic [1:0]       sub_c;
  logic [1:0]       sub_r;
  logic [CW-3:0]    last_group;

  always_comb begin
    used_w     = {width_use[CW-1:2], 2'b00};
    used_h     = {height_use[ROW_W-1:2], 2'b00};
    in_region  = (col < used_w) && (row < used_h);
    sub_c      = col[1:0];
    sub_r      = row[1:0];
    last_group = width_use[CW-1:2] - (CW-2)'(1);
    col_inc    = col + CW'(1);
    row_inc    = row + ROW_W'(1);

    for (int c = 0; c < CHANNELS; c++) begin
      if (sub_c == 2'd0) begin
        row_run_sum_next[c] = RUN_W'(pixel[c]);
      end else begin
        row_run_sum_next[c] = row_run_sum[c] + RUN_W'(pixel[c]);
      end
    end

    if (col_inc >= width_use) begin
      col_next = '0;
      row_next = (row_inc >= height_use) ? '0 : row_inc;
    end else begin
      col_next = col_inc;
      row_next = (row >= height_use) ? '0 : row;
    end

    req_load       = accept && in_region && (sub_c == 2'd3);
    req_addr       = col[GW+1:2];
    req.run        = row_run_sum_next;
    req.first_row  = (sub_r == 2'd0);
    req.emit       = (sub_r == 2'd3);
    req.frame_last = (col[CW-1:2] == last_group) && (row == used_h - ROW_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      row_run_sum <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      if (in_region) begin
        row_run_sum <= row_run_sum_next;
      end
    end
  end

endmodule

FILE: design/bxds_accum.sv
// Second stage: adds the row run sum to the column sum read from memory, writes it
// back, and holds the averaged output pixel for the master side. Depends on bxds_pkg.
module bxds_accum #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_load,
  input  bxds_pkg::acc_req_t                     req,
  input  logic [$clog2(MAX_WIDTH/4)-1:0]         req_addr,
  input  bxds_pkg::col_sum_t                     rd_data,
  output logic                                   wr_en,
  output logic [$clog2(MAX_WIDTH/4)-1:0]         wr_addr,
  output bxds_pkg::col_sum_t                     wr_data,
  output logic                                   advance,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [31:0]                            m_tdata,
  output logic                                   m_tlast
);
  import bxds_pkg::*;

  localparam int unsigned GW = $clog2(MAX_WIDTH / 4);

  logic           s1_valid;
  acc_req_t       s1_req;
  logic [GW-1:0]  s1_addr;
  col_sum_t       sum;
  pixel_t         avg;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (s1_req.first_row) begin
        sum[c] = COLSUM_W'(s1_req.run[c]);
      end else begin
        sum[c] = rd_data[c] + COLSUM_W'(s1_req.run[c]);
      end
      avg[c] = sum[c][COLSUM_W-1:4];
    end
    advance = !s1_valid || !s1_req.emit || !m_tvalid || m_tready;
    wr_en   = s1_valid && advance;
    wr_addr = s1_addr;
    wr_data = sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= req_load;
      end
      if (s1_valid && s1_req.emit && advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_load) begin
      s1_req  <= req;
      s1_addr <= req_addr;
    end
    if (s1_valid && s1_req.emit && advance) begin
      m_tdata <= avg;
      m_tlast <= s1_req.frame_last;
    end
  end

endmodule

FILE: design/box_average_downscale_by_four_unit.sv
// Top level of the 4x4 box-average downscaler for a BGRA pixel stream.
// Throughput: one input pixel per cycle; a stalled output holds off the input.
// A block's average passes the stage-one register, then the output register.
// The column-sum memory read is registered together with the stage-one request.
// Reset clears counters, run sums and valid flags; the column-sum memory is not cleared.
// Depends on bxds_pkg, bxds_front, bxds_accum and bxds_ram.
module box_average_downscale_by_four_unit #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,  // blue_in, green_in, red_in, alpha_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,  // blue_out, green_out, red_out, alpha_out
  output logic                              m_tlast,  // frame_end
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bxds_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]        cfg_data
);
  import bxds_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned GW = $clog2(MAX_WIDTH / 4);
  localparam int unsigned WX = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] in_width;
  logic [CFG_W-1:0] in_height;
  logic [WX-1:0]    width_ext;
  logic [CW-1:0]    width_use;
  logic [ROW_W-1:0] height_use;

  logic             accept;
  logic             req_load;
  acc_req_t         req;
  logic [GW-1:0]    req_addr;
  col_sum_t         rd_data;
  logic             wr_en;
  logic [GW-1:0]    wr_addr;
  col_sum_t         wr_data;
  logic             advance;
  logic             rd_en;

  assign cfg_ready = 1'b1;
  assign s_tready  = advance;
  assign accept    = s_tvalid && s_tready;
  assign rd_en     = req_load && advance;

  always_comb begin
    width_ext = WX'(in_width);
    if (width_ext < WX'(BLOCK_SIZE)) begin
      width_use = CW'(BLOCK_SIZE);
    end else if (width_ext > WX'(MAX_WIDTH)) begin
      width_use = CW'(MAX_WIDTH);
    end else begin
      width_use = CW'(width_ext);
    end
    if (in_height < BLOCK_SIZE) begin
      height_use = BLOCK_SIZE;
    end else if (in_height > HEIGHT_LIMIT) begin
      height_use = HEIGHT_LIMIT;
    end else begin
      height_use = in_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= WIDTH_RESET;
      in_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_WIDTH:  in_width  <= cfg_data;
        REG_IN_HEIGHT: in_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bxds_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel      (pixel_t'(s_tdata)),
    .width_use  (width_use),
    .height_use (height_use),
    .req_load   (req_load),
    .req        (req),
    .req_addr   (req_addr)
  );

  bxds_ram #(
    .WIDTH (CHANNELS * COLSUM_W),
    .DEPTH (MAX_WIDTH / 4)
  ) u_colsum_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (req_addr),
    .rd_data (rd_data)
  );

  bxds_accum #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .req_load (rd_en),
    .req      (req),
    .req_addr (req_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (req_addr != wr_addr))
    else $error("column sum read and write hit the same entry");

  a_read_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> accept)
    else $error("column sum read issued without an input transaction");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("waiting output transaction changed or dropped");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while the output was free");
`endif

endmodule
